// ===== src/miller_rabin_witness_test_assert.svh =====
// Assertion macros shared by the Miller-Rabin witness test RTL
`ifndef MILLER_RABIN_WITNESS_TEST_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_ASSERT_SVH

// Property that is checked when out of reset
`define MRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked when out of reset
`define MRW_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== src/mrw_pkg.sv =====
`default_nettype none
package mrw_pkg;

  localparam int Width = 64;
  localparam int CntW  = $clog2(Width + 1);

  localparam logic [1:0] VERDICT_PRIME     = 2'd0;
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
  localparam logic [1:0] VERDICT_INVALID   = 2'd2;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SPLIT  = 3'd2,
    OP_SQUARE = 3'd3,
    OP_MULT   = 3'd4,
    OP_NEXT   = 3'd5,
    OP_COUNT  = 3'd6
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic t_odd;
    logic e_bit;
    logic bits_done;
    logic mul_busy;
    logic y_one;
    logic y_nm1;
    logic sq_left;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/mrw_modmul.sv =====
`default_nettype none
// Iterative shift-and-add modular multiplier: one bit of y per cycle
module mrw_modmul (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [mrw_pkg::Width-1:0]   x,
  input  wire logic [mrw_pkg::Width-1:0]   y,
  input  wire logic [mrw_pkg::Width-1:0]   m,
  output logic                             busy,
  output logic [mrw_pkg::Width-1:0]        prod
);
  logic [mrw_pkg::Width-1:0] acc_r, acc_nxt, x_r, y_r, y_nxt, m_r;
  logic [mrw_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [mrw_pkg::Width:0]   dbl, dbl_sum;
  logic [mrw_pkg::Width-1:0] dbl_mod;

  // Double then conditionally add x, each reduced by one subtract
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_mod = (dbl >= {1'b0, m_r}) ? mrw_pkg::Width'(dbl - {1'b0, m_r})
                                   : dbl[mrw_pkg::Width-1:0];
    dbl_sum = {1'b0, dbl_mod} + {1'b0, x_r};
    acc_nxt = dbl_mod;
    if (y_r[mrw_pkg::Width-1]) begin
      acc_nxt = (dbl_sum >= {1'b0, m_r}) ? mrw_pkg::Width'(dbl_sum - {1'b0, m_r})
                                         : dbl_sum[mrw_pkg::Width-1:0];
    end
    y_nxt    = {y_r[mrw_pkg::Width-2:0], 1'b0};
    cnt_nxt  = cnt_r - 1'b1;
    busy_nxt = (cnt_r != mrw_pkg::CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= mrw_pkg::CntW'(mrw_pkg::Width);
      acc_r  <= '0;
      x_r    <= x;
      y_r    <= y;
      m_r    <= m;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      y_r    <= y_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ===== src/mrw_datapath.sv =====
`default_nettype none
// Operand registers, exponent scan and the shared modular multiplier
module mrw_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mrw_pkg::cmd_t             cmd,
  input  wire logic [mrw_pkg::Width-1:0] cand,
  input  wire logic [mrw_pkg::Width-1:0] wit,
  output mrw_pkg::stat_t                 stat
);
  localparam int W = mrw_pkg::Width;
  logic [W-1:0] n_r, a_r, t_r, y_r, nm1;
  logic [mrw_pkg::CntW-1:0] s_r, bit_r;
  logic [W-1:0] mx, prod;
  logic mbusy;

  assign nm1 = n_r - W'(1);
  assign mx  = (cmd.op == mrw_pkg::OP_MULT) ? a_r : y_r;

  mrw_modmul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.start),
    .x(mx), .y(y_r), .m(n_r), .busy(mbusy), .prod(prod)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      mrw_pkg::OP_LOAD: begin
        n_r   <= cand;
        a_r   <= wit;
        t_r   <= cand - W'(1);
        s_r   <= '0;
        bit_r <= mrw_pkg::CntW'(W);
        y_r   <= W'(1);
      end
      // Strip one trailing zero of n-1
      mrw_pkg::OP_SPLIT: begin
        t_r <= {1'b0, t_r[W-1:1]};
        s_r <= s_r + 1'b1;
      end
      // Take the product once the multiplier is done
      mrw_pkg::OP_SQUARE, mrw_pkg::OP_MULT: begin
        if (!mbusy && !cmd.start) y_r <= prod;
      end
      // Advance to the next exponent bit
      mrw_pkg::OP_NEXT: begin
        t_r   <= {t_r[W-2:0], 1'b0};
        bit_r <= bit_r - 1'b1;
      end
      // Take a follow-up square and count it off s
      mrw_pkg::OP_COUNT: begin
        y_r <= prod;
        s_r <= s_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.invalid   = (n_r < W'(3)) || (a_r == '0) || (a_r >= n_r);
    stat.t_odd     = t_r[0];
    stat.e_bit     = t_r[W-1];
    stat.bits_done = (bit_r == mrw_pkg::CntW'(1));
    stat.mul_busy  = mbusy;
    stat.y_one     = (y_r == W'(1));
    stat.y_nm1     = (y_r == nm1);
    stat.sq_left   = (s_r > mrw_pkg::CntW'(1));
  end
endmodule
`default_nettype wire

// ===== src/mrw_ctrl.sv =====
`default_nettype none
// Sequencer for one witness round
module mrw_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire mrw_pkg::stat_t stat,
  output mrw_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                done,
  output logic [1:0]          verdict
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_SPLIT  = 11'b00000000100,
    S_SQ     = 11'b00000001000,
    S_SQW    = 11'b00000010000,
    S_MUL    = 11'b00000100000,
    S_MULW   = 11'b00001000000,
    S_NEXT   = 11'b00010000000,
    S_TEST   = 11'b00100000000,
    S_LOOPW  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] verdict_r, verdict_nxt;
  logic       first_r, first_nxt;

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    first_nxt   = first_r;
    cmd.op      = mrw_pkg::OP_NONE;
    cmd.start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = mrw_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.invalid) begin
          verdict_nxt = mrw_pkg::VERDICT_INVALID;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      // Divide out powers of two from n-1
      S_SPLIT: begin
        if (!stat.t_odd) cmd.op = mrw_pkg::OP_SPLIT;
        else state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = mrw_pkg::OP_SQUARE;
        cmd.start = 1'b1;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        cmd.op = mrw_pkg::OP_SQUARE;
        if (!stat.mul_busy) state_nxt = stat.e_bit ? S_MUL : S_NEXT;
      end
      S_MUL: begin
        cmd.op    = mrw_pkg::OP_MULT;
        cmd.start = 1'b1;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        cmd.op = mrw_pkg::OP_MULT;
        if (!stat.mul_busy) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.op    = mrw_pkg::OP_NEXT;
        state_nxt = stat.bits_done ? S_TEST : S_SQ;
        if (stat.bits_done) cmd.op = mrw_pkg::OP_NONE;
        first_nxt = 1'b1;
      end
      // Exponent done: test y, then square up to s-1 times
      S_TEST: begin
        if (first_r && (stat.y_one || stat.y_nm1)) begin
          verdict_nxt = mrw_pkg::VERDICT_PRIME;
          state_nxt   = S_DONE;
        end else if (!first_r && stat.y_nm1) begin
          verdict_nxt = mrw_pkg::VERDICT_PRIME;
          state_nxt   = S_DONE;
        end else if (!first_r && stat.y_one) begin
          verdict_nxt = mrw_pkg::VERDICT_COMPOSITE;
          state_nxt   = S_DONE;
        end else if (!stat.sq_left) begin
          verdict_nxt = mrw_pkg::VERDICT_COMPOSITE;
          state_nxt   = S_DONE;
        end else begin
          cmd.op    = mrw_pkg::OP_SQUARE;
          cmd.start = 1'b1;
          state_nxt = S_LOOPW;
        end
      end
      S_LOOPW: begin
        cmd.op = mrw_pkg::OP_SQUARE;
        if (!stat.mul_busy) begin
          cmd.op    = mrw_pkg::OP_COUNT;
          first_nxt = 1'b0;
          state_nxt = S_TEST;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
    verdict_r <= verdict_nxt;
  end

  assign busy    = (state_r != S_IDLE);
  assign done    = (state_r == S_DONE);
  assign verdict = verdict_r;
endmodule
`default_nettype wire

// ===== src/miller_rabin_witness_test.sv =====
`default_nettype none
// One Miller-Rabin round on candidate n with witness a (low 64 bits each).
// A modular multiplication runs one bit of y per cycle in the shared
// shift-and-add multiplier, and an item needs up to about 190 of them (64
// squarings, up to 63 multiplies, up to 62 follow-up squarings); invalid
// operands finish without any multiplication. One item at a time is in work;
// the next transfer is taken once the verdict has been loaded into the output
// register, where it may still wait for out_tready.
module miller_rabin_witness_test (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [63:0] candidate, [127:64] witness
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata   // [1:0] verdict, [7:2] zero
);
  mrw_pkg::cmd_t  cmd;
  mrw_pkg::stat_t stat;
  logic       busy, done, in_fire;
  logic [1:0] verdict;
  logic       ovalid_r;
  logic [1:0] odata_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  mrw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!ovalid_r),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done), .verdict(verdict)
  );

  mrw_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .cand(in_tdata[63:0]), .wit(in_tdata[127:64]), .stat(stat)
  );

  // Output register: load on done, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (done && !ovalid_r) begin
      ovalid_r <= 1'b1;
      odata_r  <= verdict;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, odata_r};

`include "miller_rabin_witness_test_assert.svh"

  `MRW_IMPLY(a_no_accept_busy, busy, !in_tready, "input taken while busy")
  `MRW_IMPLY(a_verdict_code, out_tvalid, out_tdata[1:0] != 2'd3, "bad verdict code")
  `MRW_IMPLY(a_hold_result, out_tvalid && !out_tready, ##1 out_tvalid, "result dropped")
endmodule
`default_nettype wire
